FILE: rtl/mstpt_pkg.sv
// ----------------------------------------------------------------------------
// mstpt_pkg
// Types and constants for the millisecond tick timer.
// ----------------------------------------------------------------------------
package mstpt_pkg;

   localparam int MILLIS_W = 10;
   localparam int SEC_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int CODE_W   = 8;
   localparam int OP_W     = 3;

   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_RESET_TIME = 3'd1;
   localparam logic [OP_W-1:0] OP_START_PER  = 3'd2;
   localparam logic [OP_W-1:0] OP_STOP_PER   = 3'd3;
   localparam logic [OP_W-1:0] OP_START_ONE  = 3'd4;
   localparam logic [OP_W-1:0] OP_STOP_ONE   = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic               channel;
      logic [COUNT_W-1:0] count_ms;
      logic [CODE_W-1:0]  event_code;
   } req_type;

   typedef struct packed {
      logic [MILLIS_W-1:0] millis;
      logic [SEC_W-1:0]    seconds;
      logic                periodic0_fired;
      logic [CODE_W-1:0]   periodic0_code;
      logic                periodic1_fired;
      logic [CODE_W-1:0]   periodic1_code;
      logic                oneshot_fired;
      logic [CODE_W-1:0]   oneshot_code;
   } rsp_type;

   typedef struct packed {
      logic tick;
      logic clear;
   } clk_ctl_type;

   typedef struct packed {
      logic               tick;
      logic               start;
      logic               stop;
      logic [COUNT_W-1:0] count;
      logic [CODE_W-1:0]  code;
   } chan_ctl_type;

endpackage

FILE: rtl/mstpt_clock.sv
// ----------------------------------------------------------------------------
// mstpt_clock
// Millisecond / second time counter.
// ----------------------------------------------------------------------------
module mstpt_clock
   import mstpt_pkg::*;
#(
   parameter int MS_PER_SECOND = 1000
) (
   input  logic                clock,
   input  logic                reset,
   input  clk_ctl_type         ctl,
   output logic [MILLIS_W-1:0] millis_next,
   output logic [SEC_W-1:0]    seconds_next
);

   localparam logic [MILLIS_W-1:0] MS_LAST = MILLIS_W'(MS_PER_SECOND - 1);

   logic [MILLIS_W-1:0] ms_ff, ms_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;

   always_comb begin
      ms_in  = ms_ff;
      sec_in = sec_ff;
      if (ctl.clear) begin
         ms_in  = '0;
         sec_in = '0;
      end else if (ctl.tick) begin
         if (ms_ff == MS_LAST) begin
            ms_in  = '0;
            sec_in = sec_ff + 1'b1;
         end else begin
            ms_in = ms_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff  <= '0;
         sec_ff <= '0;
      end else begin
         ms_ff  <= ms_in;
         sec_ff <= sec_in;
      end
   end

   assign millis_next  = ms_in;
   assign seconds_next = sec_in;

endmodule

FILE: rtl/mstpt_periodic.sv
// ----------------------------------------------------------------------------
// mstpt_periodic
// One periodic channel: countdown with reload, fires its code at zero.
// ----------------------------------------------------------------------------
module mstpt_periodic
   import mstpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  chan_ctl_type      ctl,
   output logic [CODE_W-1:0] fire_code
);

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] reload_ff, reload_in;
   logic [CODE_W-1:0]  event_ff, event_in;
   logic               fire;

   assign fire      = ctl.tick && (event_ff != '0) && (rem_ff == '0);
   assign fire_code = fire ? event_ff : '0;

   always_comb begin
      rem_in    = rem_ff;
      reload_in = reload_ff;
      event_in  = event_ff;
      priority if (ctl.stop) begin
         rem_in    = '0;
         reload_in = '0;
         event_in  = '0;
      end else if (ctl.start) begin
         rem_in    = ctl.count;
         reload_in = ctl.count;
         event_in  = ctl.code;
      end else if (ctl.tick && (event_ff != '0)) begin
         rem_in = fire ? reload_ff : rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         reload_ff <= '0;
         event_ff  <= '0;
      end else begin
         rem_ff    <= rem_in;
         reload_ff <= reload_in;
         event_ff  <= event_in;
      end
   end

endmodule

FILE: rtl/mstpt_oneshot.sv
// ----------------------------------------------------------------------------
// mstpt_oneshot
// One-shot countdown: fires its code once at zero, then goes inactive.
// ----------------------------------------------------------------------------
module mstpt_oneshot
   import mstpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  chan_ctl_type      ctl,
   output logic [CODE_W-1:0] fire_code
);

   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [CODE_W-1:0]  event_ff, event_in;
   logic               fire;

   assign fire      = ctl.tick && (event_ff != '0) && (rem_ff == '0);
   assign fire_code = fire ? event_ff : '0;

   always_comb begin
      rem_in   = rem_ff;
      event_in = event_ff;
      priority if (ctl.stop) begin
         rem_in   = '0;
         event_in = '0;
      end else if (ctl.start) begin
         rem_in   = ctl.count;
         event_in = ctl.code;
      end else if (fire) begin
         event_in = '0;
      end else if (ctl.tick && (event_ff != '0)) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         event_ff <= '0;
      end else begin
         rem_ff   <= rem_in;
         event_ff <= event_in;
      end
   end

endmodule

FILE: rtl/ms_tick_periodic_and_oneshot_timer.sv
// ----------------------------------------------------------------------------
// ms_tick_periodic_and_oneshot_timer
// Millisecond tick timer with periodic channels and a one-shot.
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_ready  req_type (opcode, channel, count, code)
//   rsp_      out        rsp_valid/rsp_ready  rsp_type (time, fired flags, codes)
//
// One word per cycle sustained while rsp_ready stays high. A word passes through the
// input register and then the result register, which drives rsp_valid. Synchronous
// reset clears time and channels and empties both stages (their valid flags). A
// stalled result holds the pipe; the input register takes one more word while the
// result waits, then req_ready drops.
// ----------------------------------------------------------------------------
module ms_tick_periodic_and_oneshot_timer
   import mstpt_pkg::*;
#(
   parameter int NUM_PERIODIC  = 2,
   parameter int MS_PER_SECOND = 1000
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int NUM_REPORTED = 2;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    advance;

   clk_ctl_type         clk_ctl;
   chan_ctl_type        one_ctl;
   chan_ctl_type        per_ctl  [NUM_PERIODIC];
   logic [CODE_W-1:0]   per_code [NUM_PERIODIC];
   logic [CODE_W-1:0]   rpt_code [NUM_REPORTED];
   logic [CODE_W-1:0]   one_code;
   logic [MILLIS_W-1:0] millis_next;
   logic [SEC_W-1:0]    seconds_next;
   logic                is_tick;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   assign is_tick       = advance && (in_data_ff.opcode == OP_TICK);
   assign clk_ctl.tick  = is_tick;
   assign clk_ctl.clear = advance && (in_data_ff.opcode == OP_RESET_TIME);

   assign one_ctl.tick  = is_tick;
   assign one_ctl.start = advance && (in_data_ff.opcode == OP_START_ONE);
   assign one_ctl.stop  = advance && (in_data_ff.opcode == OP_STOP_ONE);
   assign one_ctl.count = in_data_ff.count_ms;
   assign one_ctl.code  = in_data_ff.event_code;

   mstpt_clock #(
      .MS_PER_SECOND(MS_PER_SECOND)
   ) u_clock (
      .clock       (clock),
      .reset       (reset),
      .ctl         (clk_ctl),
      .millis_next (millis_next),
      .seconds_next(seconds_next)
   );

   for (genvar i = 0; i < NUM_PERIODIC; i++) begin : g_per
      assign per_ctl[i].tick  = is_tick;
      assign per_ctl[i].start = advance && (in_data_ff.opcode == OP_START_PER)
                                && (32'(in_data_ff.channel) == i);
      assign per_ctl[i].stop  = advance && (in_data_ff.opcode == OP_STOP_PER)
                                && (32'(in_data_ff.channel) == i);
      assign per_ctl[i].count = in_data_ff.count_ms;
      assign per_ctl[i].code  = in_data_ff.event_code;

      mstpt_periodic u_per (
         .clock    (clock),
         .reset    (reset),
         .ctl      (per_ctl[i]),
         .fire_code(per_code[i])
      );
   end

   for (genvar r = 0; r < NUM_REPORTED; r++) begin : g_rpt
      if (r < NUM_PERIODIC) begin : g_on
         assign rpt_code[r] = per_code[r];
      end else begin : g_off
         assign rpt_code[r] = '0;
      end
   end

   mstpt_oneshot u_oneshot (
      .clock    (clock),
      .reset    (reset),
      .ctl      (one_ctl),
      .fire_code(one_code)
   );

   always_comb begin
      out_data_in.millis          = millis_next;
      out_data_in.seconds         = seconds_next;
      out_data_in.periodic0_code  = rpt_code[0];
      out_data_in.periodic0_fired = (rpt_code[0] != '0);
      out_data_in.periodic1_code  = rpt_code[1];
      out_data_in.periodic1_fired = (rpt_code[1] != '0);
      out_data_in.oneshot_code    = one_code;
      out_data_in.oneshot_fired   = (one_code != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

FILE: rtl/mstpt_checker.sv
// ----------------------------------------------------------------------------
// mstpt_checker
// Port-level checks for the millisecond tick timer.
// ----------------------------------------------------------------------------
module mstpt_checker
   import mstpt_pkg::*;
#(
   parameter int MS_PER_SECOND = 1000
) (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   localparam logic [MILLIS_W-1:0] MS_LIMIT = MILLIS_W'(MS_PER_SECOND);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   a_fired_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.periodic0_fired == (rsp_data.periodic0_code != '0))
                 && (rsp_data.periodic1_fired == (rsp_data.periodic1_code != '0))
                 && (rsp_data.oneshot_fired == (rsp_data.oneshot_code != '0)))
      else $error("fired flag disagrees with code");

   a_millis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.millis < MS_LIMIT)
      else $error("millis out of range");

endmodule

bind ms_tick_periodic_and_oneshot_timer mstpt_checker #(
   .MS_PER_SECOND(MS_PER_SECOND)
) u_mstpt_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
